[design/poc_pkg.sv]
package poc_pkg;

    // fixed field widths
    localparam int GENE_W        = 6;
    localparam int GENE_CNT      = 64;
    localparam int POS_W         = 7;
    localparam int MAX_GENES_DEF = 64;

    typedef logic [GENE_W-1:0] t_gene;
    typedef logic [POS_W-1:0]  t_pos;

    localparam t_pos CITY_RESET = t_pos'(64);

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY,
        S_FILL,
        S_GAP,
        S_EMIT
    } t_state;

    // datapath operation issued for one index
    typedef enum logic [1:0] {
        OP_NONE,
        OP_COPY,
        OP_FILL,
        OP_EMIT
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic accept;
        t_op  issue;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic load_done;
        logic copy_last;
        logic idx_last;
        logic pipe_busy;
    } t_stat;

endpackage

[design/poc_ctrl.sv]
module poc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  poc_pkg::t_stat i_stat,
    output poc_pkg::t_cmd  o_cmd
);
    import poc_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.issue  = OP_NONE;
        busy         = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy         = i_stat.pipe_busy;
                o_cmd.accept = start && !i_stat.pipe_busy;
                if (o_cmd.accept && i_stat.load_done) begin
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                o_cmd.issue = OP_COPY;
                if (i_stat.copy_last) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.issue = OP_FILL;
                if (i_stat.idx_last) begin
                    n_state = S_GAP;
                end
            end
            // lets the last fill write land before the child is read back
            S_GAP: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.issue = OP_EMIT;
                if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[design/poc_datapath.sv]
module poc_datapath #(
    parameter int MAX_GENES = poc_pkg::MAX_GENES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  poc_pkg::t_cmd            i_cmd,
    output poc_pkg::t_stat           o_stat,
    input  logic                     i_cfg_wr_en,
    input  logic [poc_pkg::POS_W-1:0] i_cfg_wr_data,
    input  poc_pkg::t_gene           i_parent_a_gene,
    input  poc_pkg::t_gene           i_parent_b_gene,
    input  poc_pkg::t_gene           i_cut_start,
    input  poc_pkg::t_gene           i_cut_end,
    output poc_pkg::t_gene           o_child_gene,
    output logic                     o_child_last,
    output logic                     o_child_valid
);
    import poc_pkg::*;

    localparam int   IDX_W   = $clog2(MAX_GENES);
    localparam int   CAP     = (MAX_GENES < GENE_CNT) ? MAX_GENES : GENE_CNT;
    localparam t_pos CAP_POS = t_pos'(CAP);

    // parent and child stores
    t_gene r_mem_a [MAX_GENES];
    t_gene r_mem_b [MAX_GENES];
    t_gene r_mem_c [MAX_GENES];
    t_gene r_a_q;
    t_gene r_b_q;
    t_gene r_c_q;

    t_pos                r_city;
    t_pos                r_load;
    t_pos                r_lo;
    t_pos                r_hi;
    t_pos                r_fp;
    t_pos                r_idx;
    t_pos                r_s1_idx;
    t_op                 r_s1_op;
    logic [GENE_CNT-1:0] r_present;
    logic [GENE_CNT-1:0] n_present;
    t_gene               r_gene;
    logic                r_last;
    logic                r_valid;

    t_pos  len;
    t_pos  len_m1;
    t_pos  load_addr;
    t_pos  load_next;
    logic  load_done;
    t_pos  cut_s;
    t_pos  cut_e;
    t_pos  cut_lo;
    t_pos  cut_hi;
    t_pos  fp_inc;
    t_pos  fp_after;
    logic  b_new;
    logic  filled;
    logic  c_we;
    t_pos  c_waddr;
    t_gene c_wdata;

    // active length and load position
    always_comb begin
        if (r_city == '0) begin
            len = t_pos'(1);
        end else if (r_city > CAP_POS) begin
            len = CAP_POS;
        end else begin
            len = r_city;
        end
        len_m1    = len - t_pos'(1);
        load_addr = (r_load >= len) ? '0 : r_load;
        load_next = load_addr + t_pos'(1);
        load_done = (load_next >= len);
    end

    // cut points: saturate, then order
    always_comb begin
        cut_s = {1'b0, i_cut_start};
        cut_e = {1'b0, i_cut_end};
        if (cut_s > len_m1) begin
            cut_s = len_m1;
        end
        if (cut_e > len_m1) begin
            cut_e = len_m1;
        end
        cut_lo = (cut_s > cut_e) ? cut_e : cut_s;
        cut_hi = (cut_s > cut_e) ? cut_s : cut_e;
    end

    // fill pointer skips over the copied segment
    always_comb begin
        b_new    = !r_present[r_b_q] && (r_fp < len);
        fp_inc   = r_fp + t_pos'(1);
        fp_after = (fp_inc == r_lo) ? (r_hi + t_pos'(1)) : fp_inc;
        filled   = ((r_s1_idx >= r_lo) && (r_s1_idx <= r_hi)) || (r_s1_idx < r_fp);
    end

    // child write port and presence bitmap
    always_comb begin
        c_we      = 1'b0;
        c_waddr   = r_s1_idx;
        c_wdata   = r_a_q;
        n_present = r_present;
        case (r_s1_op)
            OP_COPY: begin
                c_we               = 1'b1;
                n_present[r_a_q]   = 1'b1;
            end
            OP_FILL: begin
                c_waddr = r_fp;
                c_wdata = r_b_q;
                if (b_new) begin
                    c_we             = 1'b1;
                    n_present[r_b_q] = 1'b1;
                end
            end
            default: begin
                c_we = 1'b0;
            end
        endcase
        if (i_cmd.accept && load_done) begin
            n_present = '0;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.load_done = load_done;
        o_stat.copy_last = (r_idx == r_hi);
        o_stat.idx_last  = (r_idx == len_m1);
        o_stat.pipe_busy = (r_s1_op != OP_NONE);
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem_a[IDX_W'(load_addr)] <= i_parent_a_gene;
            r_mem_b[IDX_W'(load_addr)] <= i_parent_b_gene;
        end
        if (c_we) begin
            r_mem_c[IDX_W'(c_waddr)] <= c_wdata;
        end
        r_a_q <= r_mem_a[IDX_W'(r_idx)];
        r_b_q <= r_mem_b[IDX_W'(r_idx)];
        r_c_q <= r_mem_c[IDX_W'(r_idx)];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_city    <= CITY_RESET;
            r_load    <= '0;
            r_s1_op   <= OP_NONE;
            r_present <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_city <= i_cfg_wr_data;
                r_load <= '0;
            end else if (i_cmd.accept) begin
                r_load <= load_done ? '0 : load_next;
            end
            r_s1_op   <= i_cmd.issue;
            r_present <= n_present;
            r_valid   <= (r_s1_op == OP_EMIT);
        end
    end

    // cut points, pointers and output payload
    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_idx;
        if (i_cmd.accept && load_done) begin
            r_lo  <= cut_lo;
            r_hi  <= cut_hi;
            r_fp  <= (cut_lo == '0) ? (cut_hi + t_pos'(1)) : '0;
            r_idx <= cut_lo;
        end else begin
            if (r_s1_op == OP_FILL && b_new) begin
                r_fp <= fp_after;
            end
            case (i_cmd.issue)
                OP_COPY: begin
                    r_idx <= o_stat.copy_last ? '0 : (r_idx + t_pos'(1));
                end
                OP_FILL, OP_EMIT: begin
                    r_idx <= o_stat.idx_last ? '0 : (r_idx + t_pos'(1));
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
        r_gene <= filled ? r_c_q : '0;
        r_last <= (r_s1_idx == len_m1);
    end

    assign o_child_gene  = r_gene;
    assign o_child_last  = r_valid & r_last;
    assign o_child_valid = r_valid;

endmodule

[design/permutation_order_crossover.sv]
// sequence: after the transaction that completes a load of n gene pairs, the block copies
// the cut segment of parent a, fills the other slots from parent b, then passes one
// turnaround state; genes then come out one per cycle, via the read and output registers
// throughput: one gene pair per cycle while loading; no new pairs are taken while a child is
// copied, filled and emitted, set by the single read port on each gene store
// reset: synchronous active low; city_count returns to 64, any partial load is dropped
module permutation_order_crossover #(
    parameter int MAX_GENES = poc_pkg::MAX_GENES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_wr_en,
    input  logic [poc_pkg::POS_W-1:0] i_cfg_wr_data,
    input  poc_pkg::t_gene            i_parent_a_gene,
    input  poc_pkg::t_gene            i_parent_b_gene,
    input  poc_pkg::t_gene            i_cut_start,
    input  poc_pkg::t_gene            i_cut_end,
    output poc_pkg::t_gene            o_child_gene,
    output logic                      o_child_last,
    output logic                      o_child_valid
);
    import poc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencing
    poc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // stores, bitmap and pointers
    poc_datapath #(
        .MAX_GENES (MAX_GENES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_parent_a_gene (i_parent_a_gene),
        .i_parent_b_gene (i_parent_b_gene),
        .i_cut_start     (i_cut_start),
        .i_cut_end       (i_cut_end),
        .o_child_gene    (o_child_gene),
        .o_child_last    (o_child_last),
        .o_child_valid   (o_child_valid)
    );

endmodule

[design/poc_checker.sv]
module poc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_child_last,
    input logic o_child_valid
);

    // a result transaction only comes out of a busy block
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_child_valid |-> $past(busy))
        else $error("child gene without preceding busy");

    // last marker only on a valid gene
    a_last_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_child_last |-> o_child_valid)
        else $error("child_last without valid");

    // genes of one child come back to back
    a_no_gap_in_child: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_child_valid && !o_child_last |=> o_child_valid)
        else $error("gap inside a child");

    // nothing follows the last gene directly
    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_child_valid && o_child_last |=> !o_child_valid)
        else $error("gene right after last");

    // an idle block stays idle without a start
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !start |=> !busy)
        else $error("busy rose without start");

endmodule

bind permutation_order_crossover poc_checker u_poc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_child_last  (o_child_last),
    .o_child_valid (o_child_valid)
);

[tb/permutation_order_crossover_tb.sv]
module permutation_order_crossover_tb;

    import poc_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 70;
    localparam int MAX_REPORTS  = 10;

    // expected child genes, built from the loaded parents
    class crossover_scoreboard;
        logic [POS_W-1:0] city_count;
        t_gene            a_genes [GENE_CNT];
        t_gene            b_genes [GENE_CNT];
        int unsigned      loaded;
        t_gene            child_q [$];
        bit               last_q  [$];
        int unsigned      failures;
        int unsigned      children;
        int unsigned      genes_checked;

        function new();
            city_count    = CITY_RESET;
            loaded        = 0;
            failures      = 0;
            children      = 0;
            genes_checked = 0;
        endfunction

        function void set_count(logic [POS_W-1:0] value);
            city_count = value;
            loaded     = 0;
        endfunction

        // length in use after clamping to 1..64
        function int unsigned genes_in_use();
            if (city_count < 1) return 1;
            if (city_count > GENE_CNT) return GENE_CNT;
            return city_count;
        endfunction

        function int unsigned pending();
            return child_q.size();
        endfunction

        function void report(string what, string exp_s, string act_s);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("[%0t] %s: expected %s, got %s", $realtime, what, exp_s, act_s);
        endfunction

        // note one accepted gene pair; on the completing transaction build the child
        function void note_pair(t_gene a, t_gene b, t_gene cut_lo, t_gene cut_hi);
            int unsigned    n;
            int unsigned    lo;
            int unsigned    hi;
            int unsigned    tmp;
            int unsigned    fill_ptr;
            t_gene          g;
            bit [GENE_CNT-1:0] slot_used;
            bit [GENE_CNT-1:0] in_child;
            t_gene          child [GENE_CNT];
            n = genes_in_use();
            if (loaded >= n) loaded = 0;
            a_genes[loaded] = a;
            b_genes[loaded] = b;
            loaded++;
            if (loaded < n) return;

            loaded    = 0;
            slot_used = '0;
            in_child  = '0;
            fill_ptr  = 0;
            lo = cut_lo;
            hi = cut_hi;
            if (lo > n - 1) lo = n - 1;
            if (hi > n - 1) hi = n - 1;
            if (lo > hi) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end

            // segment of parent a between the cuts
            for (int i = lo; i <= hi; i++) begin
                child[i]             = a_genes[i];
                slot_used[i]         = 1'b1;
                in_child[a_genes[i]] = 1'b1;
            end

            // remaining slots from parent b in its order
            for (int i = 0; i < n; i++) begin
                g = b_genes[i];
                if (in_child[g]) continue;
                while (fill_ptr < n && slot_used[fill_ptr]) fill_ptr++;
                if (fill_ptr >= n) continue;
                child[fill_ptr]     = g;
                slot_used[fill_ptr] = 1'b1;
                in_child[g]         = 1'b1;
            end

            for (int k = 0; k < n; k++) begin
                child_q = {child_q, (slot_used[k] ? child[k] : t_gene'(0))};
                last_q  = {last_q, bit'(k == n - 1)};
            end
            children++;
        endfunction

        // compare one emitted gene with the oldest expectation
        function void check_gene(t_gene gene, logic last);
            t_gene exp_gene;
            bit    exp_last;
            if (child_q.size() == 0) begin
                report("unexpected child gene", "none",
                       $sformatf("gene %0d last %0b", gene, last));
                return;
            end
            exp_gene = child_q.pop_front();
            exp_last = last_q.pop_front();
            genes_checked++;
            if (gene !== exp_gene)
                report("child_gene mismatch", $sformatf("%0d", exp_gene),
                       $sformatf("%0d", gene));
            if (last !== exp_last)
                report("child_last mismatch", $sformatf("%0b", exp_last),
                       $sformatf("%0b", last));
        endfunction

        function void close_out();
            if (child_q.size() != 0)
                report("genes never emitted", "0", $sformatf("%0d", child_q.size()));
        endfunction
    endclass

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             start           = 1'b0;
    logic             busy;
    logic             i_cfg_wr_en     = 1'b0;
    logic [POS_W-1:0] i_cfg_wr_data   = '0;
    t_gene            i_parent_a_gene = '0;
    t_gene            i_parent_b_gene = '0;
    t_gene            i_cut_start     = '0;
    t_gene            i_cut_end       = '0;
    t_gene            o_child_gene;
    logic             o_child_last;
    logic             o_child_valid;

    crossover_scoreboard sb;
    bit                  start_hot   = 1'b0;
    bit                  quiet_phase = 1'b0;
    int unsigned         pairs_sent  = 0;
    int unsigned         cfg_writes  = 0;

    permutation_order_crossover i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_parent_a_gene (i_parent_a_gene),
        .i_parent_b_gene (i_parent_b_gene),
        .i_cut_start     (i_cut_start),
        .i_cut_end       (i_cut_end),
        .o_child_gene    (o_child_gene),
        .o_child_last    (o_child_last),
        .o_child_valid   (o_child_valid)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // result monitor, values sampled just before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_child_valid && sb != null)
            sb.check_gene(o_child_gene, o_child_last);
    end

    // one gene pair transaction, start left high for a back to back follow-up
    task automatic drive_pair(input t_gene a, input t_gene b, input t_gene cs, input t_gene ce);
        int unsigned gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            if (start_hot) start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_parent_a_gene <= a;
        i_parent_b_gene <= b;
        i_cut_start     <= cs;
        i_cut_end       <= ce;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start_hot = 1'b1;
        sb.note_pair(a, b, cs, ce);
        pairs_sent++;
    endtask

    task automatic release_start();
        if (start_hot) begin
            start <= 1'b0;
            @(posedge i_clk);
            start_hot = 1'b0;
        end
    endtask

    // hold off until every expected gene is out and the block has settled
    task automatic wait_drained();
        release_start();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_city(input logic [POS_W-1:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        sb.set_count(value);
        cfg_writes++;
        i_cfg_wr_en   <= 1'b0;
    endtask

    // parents in position order, cut points on the final pair
    task automatic send_parents(input t_gene a[$], input t_gene b[$],
                                input t_gene cs, input t_gene ce);
        for (int i = 0; i < a.size(); i++) begin
            if (i == a.size() - 1)
                drive_pair(a[i], b[i], cs, ce);
            else
                drive_pair(a[i], b[i], t_gene'($urandom_range(0, 63)),
                           t_gene'($urandom_range(0, 63)));
        end
    endtask

    task automatic shuffle(ref t_gene q[$]);
        int unsigned j;
        t_gene       tmp;
        for (int i = q.size() - 1; i > 0; i--) begin
            j    = $urandom_range(0, i);
            tmp  = q[i];
            q[i] = q[j];
            q[j] = tmp;
        end
    endtask

    // random child of length n; kind picks permutation, junk or broken load
    task automatic random_child(input int unsigned n);
        t_gene       pool [$];
        t_gene       a [$];
        t_gene       b [$];
        int unsigned kind;
        t_gene       cs;
        t_gene       ce;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < GENE_CNT; i++) pool = {pool, t_gene'(i)};
        shuffle(pool);
        if (kind <= 6) begin
            for (int i = 0; i < n; i++) a = {a, pool[i]};
            b = a;
            shuffle(a);
            shuffle(b);
        end else begin
            for (int i = 0; i < n; i++) begin
                a = {a, t_gene'($urandom_range(0, 63))};
                b = {b, t_gene'($urandom_range(0, 63))};
            end
        end
        cs = ($urandom_range(0, 3) == 0) ? t_gene'($urandom_range(0, 63))
                                         : t_gene'($urandom_range(0, n - 1));
        ce = ($urandom_range(0, 3) == 0) ? t_gene'($urandom_range(0, 63))
                                         : t_gene'($urandom_range(0, n - 1));
        if (kind == 9 && n > 1) begin
            // broken load, dropped by a rewrite of the length
            a = a[0:$urandom_range(0, n - 2)];
            b = b[0:a.size() - 1];
            send_parents(a, b, cs, ce);
            write_city(sb.city_count);
        end else begin
            send_parents(a, b, cs, ce);
        end
    endtask

    initial begin
        int unsigned      r;
        int unsigned      nkids;
        logic [POS_W-1:0] city;
        int unsigned      random_base;

        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one child at the reset length
        quiet_phase = 1'b1;
        random_child(GENE_CNT);

        // directed: single gene with extreme genes and cuts
        quiet_phase = 1'b0;
        write_city(7'd1);
        send_parents('{6'd63}, '{6'd0}, 6'd63, 6'd63);
        send_parents('{6'd0}, '{6'd63}, 6'd0, 6'd0);
        // zero length runs as one gene
        write_city(7'd0);
        send_parents('{6'd42}, '{6'd21}, 6'd0, 6'd63);
        // the start cut saturates to the last position, then the cuts are swapped
        write_city(7'd2);
        send_parents('{6'd0, 6'd63}, '{6'd63, 6'd0}, 6'd63, 6'd0);
        // cuts in reverse order get swapped, whole child from parent a
        write_city(7'd3);
        send_parents('{6'd10, 6'd20, 6'd30}, '{6'd30, 6'd20, 6'd10}, 6'd2, 6'd0);
        // disjoint parents, a gene of b finds no free slot
        send_parents('{6'd1, 6'd2, 6'd3}, '{6'd4, 6'd5, 6'd6}, 6'd1, 6'd1);
        // duplicates in b leave a slot empty
        send_parents('{6'd0, 6'd1, 6'd2}, '{6'd1, 6'd1, 6'd1}, 6'd0, 6'd0);
        // partial load dropped by a length write
        write_city(7'd4);
        send_parents('{6'd5, 6'd6}, '{6'd6, 6'd5}, 6'd0, 6'd3);
        write_city(7'd4);
        send_parents('{6'd7, 6'd8, 6'd9, 6'd10}, '{6'd10, 6'd9, 6'd8, 6'd7}, 6'd1, 6'd2);
        // out of range length clamps to 64
        write_city(7'd127);
        quiet_phase = 1'b1;
        random_child(GENE_CNT);

        // random phases, mostly short children
        random_base = pairs_sent;
        while (pairs_sent < random_base + RANDOM_ITEMS) begin
            r = $urandom_range(0, 19);
            case (r)
                0: city = 7'd0;
                1: city = 7'd127;
                2: city = 7'd64;
                3: city = POS_W'($urandom_range(65, 126));
                4, 5, 6: city = POS_W'($urandom_range(11, 40));
                default: city = POS_W'($urandom_range(1, 10));
            endcase
            write_city(city);
            quiet_phase = ($urandom_range(0, 3) == 0);
            nkids = (sb.genes_in_use() > 20) ? 1 : $urandom_range(1, 4);
            repeat (nkids) random_child(sb.genes_in_use());
        end

        wait_drained();
        sb.close_out();
        $display("covered %0d gene pairs, %0d children, %0d genes checked, %0d length writes",
                 pairs_sent, sb.children, sb.genes_checked, cfg_writes);
        $display("%0d failures found", sb.failures);
        if (sb.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run limit
    initial begin
        #(2 * CLK_HALF * 400000);
        $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
design/poc_pkg.sv
design/poc_ctrl.sv
design/poc_datapath.sv
design/permutation_order_crossover.sv
design/poc_checker.sv
tb/permutation_order_crossover_tb.sv
